### hw/rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation package
// Shared payload types and an arithmetic shift helper for the compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned TrimW   = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_TRIM_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_C = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIM_D = 2'd3;

  localparam logic [31:0] HumLimit = 32'd419430400;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_pa;
    logic               press_invalid;
    logic [16:0]        hum_q10;
  } out_t;

  // Arithmetic right shift of a 32-bit word held as raw bits
  function automatic logic [31:0] asr(logic [31:0] x, logic [4:0] n);
    asr = $unsigned($signed(x) >>> n);
  endfunction

endpackage

### hw/rtl/esc_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring 32/32 division, one quotient bit per register stage, side data
// travels alongside.
// ----------------------------------------------------------------------------
module esc_div #(
  parameter int unsigned SideW = 66
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);

  localparam int unsigned Steps = 32;

  logic [31:0]      rem_q  [Steps];
  logic [31:0]      num_q  [Steps];
  logic [31:0]      quo_q  [Steps];
  logic [31:0]      den_q  [Steps];
  logic [SideW-1:0] side_q [Steps];
  logic [Steps-1:0] vld_q;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [31:0]      r_in, n_in, q_in, d_in;
    logic [SideW-1:0] s_in;
    logic             v_in;
    logic [32:0]      r_sh, r_sub;
    logic             take;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
      assign v_in = vld_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign n_in = num_q[k-1];
      assign q_in = quo_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign r_sh  = {r_in, n_in[31]};
    assign r_sub = r_sh - {1'b0, d_in};
    assign take  = (r_sh >= {1'b0, d_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? r_sub[31:0] : r_sh[31:0];
        num_q[k]  <= {n_in[30:0], 1'b0};
        quo_q[k]  <= {q_in[30:0], take};
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[Steps-1];
  assign quo_o  = quo_q[Steps-1];
  assign side_o = side_q[Steps-1];

endmodule

### hw/rtl/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation top level
// Turns raw temperature, pressure and humidity readings into compensated
// values using the 32 trim bytes held in four configuration words.
// ----------------------------------------------------------------------------
// Pipeline: 10 front stages, 32 pressure divider stages and 3 back stages.
// Throughput: one reading per cycle; the whole pipeline holds while a
//   finished result waits at the output.
// Reset: asynchronous, active low; clears all stage valid bits and the trim
//   words to zero.
module env_sensor_compensation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  esc_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output esc_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [esc_pkg::TrimW-1:0]     cfg_wdata_i
);

  localparam int unsigned FrontN = 10;
  localparam int unsigned BackN  = 3;
  localparam int unsigned SideW  = 66;

  // --------------------------------------------------------------------------
  // Trim words and coefficient unpacking
  // --------------------------------------------------------------------------
  logic [esc_pkg::TrimW-1:0] trim_q [4];
  logic [255:0] trim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q[0] <= '0;
      trim_q[1] <= '0;
      trim_q[2] <= '0;
      trim_q[3] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esc_pkg::CFG_TRIM_A: trim_q[0] <= cfg_wdata_i;
        esc_pkg::CFG_TRIM_B: trim_q[1] <= cfg_wdata_i;
        esc_pkg::CFG_TRIM_C: trim_q[2] <= cfg_wdata_i;
        esc_pkg::CFG_TRIM_D: trim_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign trim = {trim_q[3], trim_q[2], trim_q[1], trim_q[0]};

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  // Unsigned coefficients zero-extend, the rest sign-extend to 32 bits
  assign t1 = {16'b0, trim[15:0]};
  assign t2 = {{16{trim[31]}}, trim[31:16]};
  assign t3 = {{16{trim[47]}}, trim[47:32]};
  assign p1 = {16'b0, trim[63:48]};
  assign p2 = {{16{trim[79]}}, trim[79:64]};
  assign p3 = {{16{trim[95]}}, trim[95:80]};
  assign p4 = {{16{trim[111]}}, trim[111:96]};
  assign p5 = {{16{trim[127]}}, trim[127:112]};
  assign p6 = {{16{trim[143]}}, trim[143:128]};
  assign p7 = {{16{trim[159]}}, trim[159:144]};
  assign p8 = {{16{trim[175]}}, trim[175:160]};
  assign p9 = {{16{trim[191]}}, trim[191:176]};
  assign h1 = {24'b0, trim[199:192]};
  assign h2 = {{16{trim[215]}}, trim[215:200]};
  assign h3 = {24'b0, trim[223:216]};
  // H4 takes the low nibble of byte 29, H5 the high nibble
  assign h4 = {{20{trim[231]}}, trim[231:224], trim[235:232]};
  assign h5 = {{20{trim[247]}}, trim[247:240], trim[239:236]};
  assign h6 = {{24{trim[255]}}, trim[255:248]};

  // --------------------------------------------------------------------------
  // Pipeline control: advance everything unless the output holds a result
  // --------------------------------------------------------------------------
  logic en;
  logic [FrontN-1:0] fvld_q;
  logic [BackN-1:0]  bvld_q;
  logic div_vld;

  assign en          = !bvld_q[BackN-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = bvld_q[BackN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q <= '0;
      bvld_q <= '0;
    end else if (en) begin
      fvld_q <= {fvld_q[FrontN-2:0], in_valid_i};
      bvld_q <= {bvld_q[BackN-2:0], div_vld};
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: temperature, pressure terms and humidity product
  // --------------------------------------------------------------------------
  logic [31:0] x1, dt;
  assign x1 = {15'b0, in_data_i.adc_temp[19:3]} - {t1[30:0], 1'b0};
  assign dt = {16'b0, in_data_i.adc_temp[19:4]} - t1;

  logic [31:0] s1_ta_q, s1_dd_q;
  logic [19:0] s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q;
  logic [19:0] s5_adcp_q, s6_adcp_q, s7_adcp_q;
  logic [15:0] s1_adch_q, s2_adch_q, s3_adch_q, s4_adch_q, s5_adch_q;
  logic [31:0] s2_a_q, s2_b1_q, s3_fine_q;
  logic [31:0] s4_temp_q, s4_pa_q, s4_v_q;
  logic [31:0] s5_pdd_q, s5_pa5_q, s5_pa2_q, s5_hv5_q, s5_hv6_q, s5_hv3_q;
  logic [31:0] s6_b_q, s6_c3_q, s6_ha_q, s6_hm1_q, s6_hm2_q, s6_pa5_q, s6_pa2_q;
  logic [31:0] s7_b_q, s7_a_q, s7_hprod_q, s7_ha_q;
  logic [31:0] s8_a_q, s8_pnum_q, s8_hb_q, s8_ha_q;
  logic [31:0] s9_div_q, s9_pm_q, s9_hb2_q, s9_ha_q;
  logic [31:0] s10_hv_q, s10_num_q, s10_div_q;
  logic        s10_big_q, s10_inv_q;
  logic [31:0] s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q, s9_temp_q, s10_temp_q;
  logic [31:0] pd, ha_raw;

  assign pd     = esc_pkg::asr(s4_pa_q, 5'd2);
  assign ha_raw = {2'b0, s5_adch_q, 14'b0} - {h4[11:0], 20'b0} - s5_hv5_q + 32'd16384;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: first temperature products
      s1_ta_q   <= x1 * t2;
      s1_dd_q   <= dt * dt;
      s1_adcp_q <= in_data_i.adc_press;
      s1_adch_q <= in_data_i.adc_hum;
      // Stage 2
      s2_a_q    <= esc_pkg::asr(s1_ta_q, 5'd11);
      s2_b1_q   <= esc_pkg::asr(s1_dd_q, 5'd12) * t3;
      s2_adcp_q <= s1_adcp_q;
      s2_adch_q <= s1_adch_q;
      // Stage 3: fine temperature
      s3_fine_q <= s2_a_q + esc_pkg::asr(s2_b1_q, 5'd14);
      s3_adcp_q <= s2_adcp_q;
      s3_adch_q <= s2_adch_q;
      // Stage 4: temperature result, pressure and humidity offsets
      s4_temp_q <= esc_pkg::asr(s3_fine_q * 32'd5 + 32'd128, 5'd8);
      s4_pa_q   <= esc_pkg::asr(s3_fine_q, 5'd1) - 32'd64000;
      s4_v_q    <= s3_fine_q - 32'd76800;
      s4_adcp_q <= s3_adcp_q;
      s4_adch_q <= s3_adch_q;
      // Stage 5: independent products of the offsets
      s5_pdd_q  <= pd * pd;
      s5_pa5_q  <= s4_pa_q * p5;
      s5_pa2_q  <= p2 * s4_pa_q;
      s5_hv5_q  <= h5 * s4_v_q;
      s5_hv6_q  <= s4_v_q * h6;
      s5_hv3_q  <= s4_v_q * h3;
      s5_temp_q <= s4_temp_q;
      s5_adcp_q <= s4_adcp_q;
      s5_adch_q <= s4_adch_q;
      // Stage 6
      s6_b_q    <= esc_pkg::asr(s5_pdd_q, 5'd11) * p6;
      s6_c3_q   <= p3 * esc_pkg::asr(s5_pdd_q, 5'd13);
      s6_ha_q   <= esc_pkg::asr(ha_raw, 5'd15);
      s6_hm1_q  <= esc_pkg::asr(s5_hv6_q, 5'd10);
      s6_hm2_q  <= esc_pkg::asr(s5_hv3_q, 5'd11) + 32'd32768;
      s6_pa5_q  <= s5_pa5_q;
      s6_pa2_q  <= s5_pa2_q;
      s6_temp_q <= s5_temp_q;
      s6_adcp_q <= s5_adcp_q;
      // Stage 7
      s7_b_q     <= esc_pkg::asr(s6_b_q + {s6_pa5_q[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'b0};
      s7_a_q     <= esc_pkg::asr(esc_pkg::asr(s6_c3_q, 5'd3)
                    + esc_pkg::asr(s6_pa2_q, 5'd1), 5'd18);
      s7_hprod_q <= s6_hm1_q * s6_hm2_q;
      s7_ha_q    <= s6_ha_q;
      s7_temp_q  <= s6_temp_q;
      s7_adcp_q  <= s6_adcp_q;
      // Stage 8
      s8_a_q    <= (32'd32768 + s7_a_q) * p1;
      s8_pnum_q <= (32'd1048576 - {12'b0, s7_adcp_q}) - esc_pkg::asr(s7_b_q, 5'd12);
      s8_hb_q   <= esc_pkg::asr(s7_hprod_q, 5'd10) + 32'd2097152;
      s8_ha_q   <= s7_ha_q;
      s8_temp_q <= s7_temp_q;
      // Stage 9: divisor and scaled numerator
      s9_div_q  <= esc_pkg::asr(s8_a_q, 5'd15);
      s9_pm_q   <= s8_pnum_q * 32'd3125;
      s9_hb2_q  <= s8_hb_q * h2 + 32'd8192;
      s9_ha_q   <= s8_ha_q;
      s9_temp_q <= s8_temp_q;
      // Stage 10: pick the numerator form that fits 32 bits
      s10_hv_q   <= s9_ha_q * esc_pkg::asr(s9_hb2_q, 5'd14);
      s10_big_q  <= s9_pm_q[31];
      s10_num_q  <= s9_pm_q[31] ? s9_pm_q : {s9_pm_q[30:0], 1'b0};
      s10_div_q  <= s9_div_q;
      s10_inv_q  <= (s9_div_q == '0);
      s10_temp_q <= s9_temp_q;
    end
  end

  // --------------------------------------------------------------------------
  // Pressure divider; temperature and humidity ride along as side data
  // --------------------------------------------------------------------------
  logic [31:0]      div_quo;
  logic [SideW-1:0] div_side;

  esc_div #(
    .SideW (SideW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fvld_q[FrontN-1]),
    .num_i  (s10_num_q),
    .den_i  (s10_div_q),
    .side_i ({s10_temp_q, s10_hv_q, s10_big_q, s10_inv_q}),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  logic [31:0] d_temp, d_hv, qf, hd;
  logic        d_big, d_inv;

  assign {d_temp, d_hv, d_big, d_inv} = div_side;
  assign qf = d_big ? {div_quo[30:0], 1'b0} : div_quo;
  assign hd = esc_pkg::asr(d_hv, 5'd15);

  // --------------------------------------------------------------------------
  // Back stages: pressure correction and humidity finish
  // --------------------------------------------------------------------------
  logic [31:0] b1_qf_q, b1_sq_q, b1_pb_q, b1_hdd_q, b1_hv_q, b1_temp_q;
  logic        b1_inv_q;
  logic [31:0] b2_qf_q, b2_a9_q, b2_b8_q, b2_ht_q, b2_hv_q, b2_temp_q;
  logic        b2_inv_q;
  logic [31:0] qs3, hum_v;
  esc_pkg::out_t out_q;

  assign qs3   = {3'b0, qf[31:3]};
  assign hum_v = b2_hv_q - esc_pkg::asr(b2_ht_q, 5'd4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_qf_q   <= qf;
      b1_sq_q   <= qs3 * qs3;
      b1_pb_q   <= {2'b0, qf[31:2]} * p8;
      b1_hdd_q  <= hd * hd;
      b1_hv_q   <= d_hv;
      b1_temp_q <= d_temp;
      b1_inv_q  <= d_inv;

      b2_qf_q   <= b1_qf_q;
      b2_a9_q   <= esc_pkg::asr(p9 * {13'b0, b1_sq_q[31:13]}, 5'd12);
      b2_b8_q   <= esc_pkg::asr(b1_pb_q, 5'd13);
      b2_ht_q   <= esc_pkg::asr(b1_hdd_q, 5'd7) * h1;
      b2_hv_q   <= b1_hv_q;
      b2_temp_q <= b1_temp_q;
      b2_inv_q  <= b1_inv_q;

      // Drop the pressure to zero on a zero divisor; clamp humidity
      out_q.temp_centi    <= $signed(b2_temp_q);
      out_q.press_invalid <= b2_inv_q;
      out_q.press_pa      <= b2_inv_q ? '0 :
                             b2_qf_q + esc_pkg::asr(b2_a9_q + b2_b8_q + p7, 5'd4);
      if (hum_v[31]) begin
        out_q.hum_q10 <= '0;
      end else if (hum_v > esc_pkg::HumLimit) begin
        out_q.hum_q10 <= esc_pkg::HumLimit[28:12];
      end else begin
        out_q.hum_q10 <= hum_v[28:12];
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### hw/rtl/esc_checker.sv
// ----------------------------------------------------------------------------
// Environmental sensor compensation port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
module esc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input esc_pkg::out_t out_data_o
);

  // Hold a refused result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.hum_q10 <= 17'd102400)
    else $error("humidity above clamp");

  a_press_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.press_invalid |-> out_data_o.press_pa == '0)
    else $error("invalid pressure not zero");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input refused without output stall");

endmodule

bind env_sensor_compensation_top esc_checker u_esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### tb/tb_env_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Environmental sensor compensation testbench
// Drives raw readings through the valid/ready input with random gaps, stalls
// the result side at random and checks every result against a compensation
// predictor fed by its own copy of the four trim words. The trim words are
// rewritten between phases: all zero, all ones, a typical factory trim,
// perturbed trims and fully random words.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation_top;

  // Expected results of the compensation, in transfer order
  class comp_scoreboard;
    logic [esc_pkg::TrimW-1:0] trim [4];
    esc_pkg::out_t             expected_q [$];
    int unsigned               n_checked;
    int unsigned               n_errors;

    function new();
      foreach (trim[i]) trim[i] = '0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function automatic logic [31:0] sra(logic [31:0] x, int unsigned n);
      return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [7:0] tb8(int unsigned k);
      logic [255:0] all_bytes;
      all_bytes = {trim[3], trim[2], trim[1], trim[0]};
      return all_bytes[8*k +: 8];
    endfunction

    function automatic logic [31:0] tu16(int unsigned k);
      return {16'b0, tb8(k+1), tb8(k)};
    endfunction

    function automatic logic [31:0] ts16(int unsigned k);
      logic [15:0] w;
      w = {tb8(k+1), tb8(k)};
      return {{16{w[15]}}, w};
    endfunction

    // Compensate one reading with the current trim
    function automatic esc_pkg::out_t compensate(esc_pkg::in_t rd);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] at, ap, ah, a, b, d, fine, temp, press, v;
      logic [11:0] h4r, h5r;
      logic [7:0]  b29, b31;
      esc_pkg::out_t r;
      at = {12'b0, rd.adc_temp};
      ap = {12'b0, rd.adc_press};
      ah = {16'b0, rd.adc_hum};
      t1 = tu16(0);  t2 = ts16(2);  t3 = ts16(4);  p1 = tu16(6);
      p2 = ts16(8);  p3 = ts16(10); p4 = ts16(12); p5 = ts16(14);
      p6 = ts16(16); p7 = ts16(18); p8 = ts16(20); p9 = ts16(22);
      h1 = {24'b0, tb8(24)};
      h2 = ts16(25);
      h3 = {24'b0, tb8(27)};
      b29 = tb8(29);
      b31 = tb8(31);
      h4r = {tb8(28), b29[3:0]};
      h5r = {tb8(30), b29[7:4]};
      h4 = {{20{h4r[11]}}, h4r};
      h5 = {{20{h5r[11]}}, h5r};
      h6 = {{24{b31[7]}}, b31};
      r.press_invalid = 1'b0;

      a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
      d = (at >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      temp = sra(fine * 32'd5 + 32'd128, 8);

      a = sra(fine, 1) - 32'd64000;
      d = sra(a, 2);
      b = sra(d * d, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(d * d, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      if (a == 32'd0) begin
        press = '0;
        r.press_invalid = 1'b1;
      end else begin
        press = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
        if (press < 32'h8000_0000) press = (press << 1) / a;
        else press = (press / a) * 32'd2;
        a = sra(p9 * (((press >> 3) * (press >> 3)) >> 13), 12);
        b = sra((press >> 2) * p8, 13);
        press = press + sra(a + b + p7, 4);
      end

      v = fine - 32'd76800;
      a = sra(((ah << 14) - (h4 << 20) - (h5 * v)) + 32'd16384, 15);
      b = sra(sra(v * h6, 10) * (sra(v * h3, 11) + 32'd32768), 10) + 32'd2097152;
      b = sra(b * h2 + 32'd8192, 14);
      v = a * b;
      d = sra(v, 15);
      v = v - sra(sra(d * d, 7) * h1, 4);
      if (v[31]) v = '0;
      else if (v > 32'd419430400) v = 32'd419430400;

      r.temp_centi = temp;
      r.press_pa   = press;
      r.hum_q10    = v[28:12];
      return r;
    endfunction

    function void note_input(esc_pkg::in_t rd);
      expected_q.push_back(compensate(rd));
    endfunction

    function void check_result(esc_pkg::out_t got);
      esc_pkg::out_t exp_r;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      n_checked++;
      if (got.temp_centi !== exp_r.temp_centi || got.press_pa !== exp_r.press_pa ||
          got.press_invalid !== exp_r.press_invalid || got.hum_q10 !== exp_r.hum_q10) begin
        n_errors++;
        if (n_errors <= 10)
          $display({"ERROR: result %0d: expected T=%0d P=%0d inv=%0d H=%0d, ",
                    "got T=%0d P=%0d inv=%0d H=%0d"},
                   n_checked, exp_r.temp_centi, exp_r.press_pa, exp_r.press_invalid,
                   exp_r.hum_q10, got.temp_centi, got.press_pa, got.press_invalid,
                   got.hum_q10);
      end
    endfunction
  endclass

  // Typical factory trim, packed little-endian into the four words
  localparam logic [63:0] TypTrimA = {16'd36477, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypTrimB = {16'd140, 16'd2855, 16'd3024, 16'hD643};
  localparam logic [63:0] TypTrimC = {16'd6000, 16'hC6F8, 16'd15500, 16'hFFF9};
  localparam logic [63:0] TypTrimD = {8'h1E, 8'h00, 8'h04, 8'h14, 8'h00, 8'h01, 8'h6A, 8'd75};

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 60;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  esc_pkg::in_t                 in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  esc_pkg::out_t                out_data_o;
  logic                         cfg_we_i;
  logic [esc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [esc_pkg::TrimW-1:0]    cfg_wdata_i;

  comp_scoreboard sb;
  int unsigned    n_sent;
  int unsigned    idle_cycles;
  bit             burst_mode;   // no idling on either side while set

  env_sensor_compensation_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold valid and payload until the transfer, then note the reading
  task automatic send_reading(esc_pkg::in_t rd);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = rd;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(rd);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Wait for the pipeline to drain, then write one trim word
  task automatic write_trim(logic [esc_pkg::CfgIdxW-1:0] idx,
                            logic [esc_pkg::TrimW-1:0] val);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.trim[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_trim(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d);
    write_trim(esc_pkg::CFG_TRIM_A, a);
    write_trim(esc_pkg::CFG_TRIM_B, b);
    write_trim(esc_pkg::CFG_TRIM_C, c);
    write_trim(esc_pkg::CFG_TRIM_D, d);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Plausible readings most of the time, full-range noise otherwise
  function automatic esc_pkg::in_t random_reading();
    esc_pkg::in_t rd;
    if ($urandom_range(0, 5) == 0) begin
      rd.adc_temp  = 20'($urandom());
      rd.adc_press = 20'($urandom());
      rd.adc_hum   = 16'($urandom());
    end else begin
      rd.adc_temp  = 20'($urandom_range(400000, 600000));
      rd.adc_press = 20'($urandom_range(250000, 500000));
      rd.adc_hum   = 16'($urandom_range(15000, 50000));
    end
    return rd;
  endfunction

  function automatic esc_pkg::in_t mk(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    esc_pkg::in_t rd;
    rd.adc_temp  = t;
    rd.adc_press = p;
    rd.adc_hum   = h;
    return rd;
  endfunction

  // Results side: random stalls, checked at the rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= burst_mode ? 1'b1 : ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    esc_pkg::in_t rd;
    sb          = new();
    n_sent      = 0;
    burst_mode  = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = esc_pkg::CFG_TRIM_A;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset trim: P1 is zero, so the pressure divisor is zero
    send_reading(mk('0, '0, '0));
    send_reading(mk('1, '1, '1));
    send_reading(mk(20'd519888, 20'd415148, 16'd30000));

    // Typical trim: field extremes and both humidity clamps
    load_trim(TypTrimA, TypTrimB, TypTrimC, TypTrimD);
    send_reading(mk(20'd519888, 20'd415148, 16'd30000));
    send_reading(mk('0, '0, '0));
    send_reading(mk('1, '1, '1));
    send_reading(mk('0, '1, 16'd30000));
    send_reading(mk('1, '0, 16'd30000));
    send_reading(mk(20'd519888, 20'd415148, '0));
    send_reading(mk(20'd519888, 20'd415148, '1));
    send_reading(mk(20'd600000, 20'd300000, 16'd65000));
    send_reading(mk(20'd400000, 20'd500000, 16'd10));
    send_reading(mk(20'h55555, 20'hAAAAA, 16'h5555));
    send_reading(mk(20'hAAAAA, 20'h55555, 16'hAAAA));

    // All-ones trim: signed coefficients at minus one, unsigned ones at their top value
    load_trim('1, '1, '1, '1);
    send_reading(mk('0, '0, '0));
    send_reading(mk('1, '1, '1));
    send_reading(mk(20'd519888, 20'd415148, 16'd30000));
    send_reading(mk(20'h80000, 20'h80000, 16'h8000));

    // Random phases: cycle through trim styles, some with bursts
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 5)
        0: load_trim(TypTrimA, TypTrimB, TypTrimC, TypTrimD);
        1: load_trim(TypTrimA ^ (rand64() & 64'h00FF_00FF_00FF_00FF),
                     TypTrimB ^ (rand64() & 64'h00FF_00FF_00FF_00FF),
                     TypTrimC ^ (rand64() & 64'h00FF_00FF_00FF_00FF),
                     TypTrimD ^ (rand64() & 64'hFF00_0F00_00FF_00FF));
        2: load_trim(rand64(), rand64(), rand64(), rand64());
        3: load_trim('0, '0, '0, '0);
        default: load_trim(TypTrimA & 64'h0000_FFFF_FFFF_FFFF, rand64(), rand64(), rand64());
      endcase
      burst_mode = (ph == 2) || (ph == 6);
      for (int i = 0; i < 104; i++) begin
        rd = random_reading();
        send_reading(rd);
      end
      burst_mode = 1'b0;
    end
    in_valid_i = 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d readings over 11 trim settings; %0d results checked, %0d mismatches",
             n_sent, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### env_sensor_compensation_top.f
hw/rtl/esc_pkg.sv
hw/rtl/esc_div.sv
hw/rtl/env_sensor_compensation_top.sv
hw/rtl/esc_checker.sv
tb/tb_env_sensor_compensation_top.sv
